// File: rtl/core/fpm_pkg.sv
// shared types, constants and codes of the frame psnr meter
package fpm_pkg;

   localparam int unsigned MAX_WIDTH_DEF  = 2048;
   localparam int unsigned MAX_HEIGHT_DEF = 2048;

   localparam int unsigned LUMA_W    = 8;
   localparam int unsigned DIM_CFG_W = 12;
   localparam int unsigned SEQ_CFG_W = 16;
   localparam int unsigned INDEX_W   = 16;
   localparam int unsigned SSE_OUT_W = 38;
   localparam int unsigned PSNR_W    = 15;

   localparam int unsigned CSR_ADDR_W = 4;
   localparam int unsigned CSR_DATA_W = 32;

   localparam int unsigned PSNR_FRAC_BITS = 8;
   localparam int unsigned LOG_FRAC       = 24;
   localparam int unsigned LOG_INT_W      = 6;
   localparam int unsigned LOG_W          = LOG_INT_W + LOG_FRAC;
   localparam int unsigned ROUND_SHIFT    = LOG_FRAC + 30 - PSNR_FRAC_BITS;

   localparam logic [31:0]       TEN_LOG10_2_Q30 = 32'd3232284966;
   localparam logic [16:0]       PEAK_SQ         = 17'd65025;
   localparam logic [PSNR_W-1:0] PSNR_SAT        = 15'h7fff;

   localparam int unsigned DIV_DIVIDEND_W = 33;
   localparam int unsigned DIV_N_W        = 17;

   typedef enum logic [1:0] {
      CSR_FRAME_WIDTH     = 2'd0,
      CSR_FRAME_HEIGHT    = 2'd1,
      CSR_SEQUENCE_FRAMES = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic [DIM_CFG_W-1:0] frame_width;
      logic [DIM_CFG_W-1:0] frame_height;
      logic [SEQ_CFG_W-1:0] sequence_frames;
   } cfg_type;

   typedef enum logic [3:0] {
      OP_IDLE,
      OP_WH,
      OP_PEAK,
      OP_NORM,
      OP_MANT,
      OP_SQ,
      OP_UPD,
      OP_SAVE,
      OP_DIFF,
      OP_ROUND,
      OP_ACC,
      OP_DIV,
      OP_EMIT
   } dp_op_type;

   typedef struct packed {
      dp_op_type  op;
      logic       pixel;
      logic       second;
      logic [4:0] bit_idx;
   } dp_cmd_type;

   typedef struct packed {
      logic frame_last;
      logic sse_zero;
      logic msb_set;
      logic out_free;
   } dp_status_type;

endpackage

// File: rtl/core/fpm_if.sv
// valid/ready channel interfaces for pixel pairs and frame results
interface fpm_req_if;
   logic                        valid;
   logic                        ready;
   logic [fpm_pkg::LUMA_W-1:0]  ref_luma;
   logic [fpm_pkg::LUMA_W-1:0]  test_luma;

   modport source (output valid, output ref_luma, output test_luma, input ready);
   modport sink   (input valid, input ref_luma, input test_luma, output ready);
endinterface

interface fpm_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [fpm_pkg::INDEX_W-1:0]   frame_index;
   logic [fpm_pkg::SSE_OUT_W-1:0] frame_sse;
   logic [fpm_pkg::PSNR_W-1:0]    frame_psnr_q8;
   logic                          identical_frame;
   logic [fpm_pkg::PSNR_W-1:0]    average_psnr_q8;
   logic                          sequence_done;

   modport source (output valid, output frame_index, output frame_sse,
                   output frame_psnr_q8, output identical_frame,
                   output average_psnr_q8, output sequence_done, input ready);
   modport sink   (input valid, input frame_index, input frame_sse,
                   input frame_psnr_q8, input identical_frame,
                   input average_psnr_q8, input sequence_done, output ready);
endinterface

// File: rtl/core/fpm_ctrl.sv
// sequencer for the end-of-frame log, psnr and average computation
module fpm_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  fpm_pkg::dp_status_type status,
   output fpm_pkg::dp_cmd_type    cmd
);

   typedef enum logic [3:0] {
      S_IDLE, S_WH, S_PEAK, S_NORM, S_MANT, S_SQ, S_UPD, S_SAVE,
      S_DIFF, S_ROUND, S_ACC, S_DIV, S_EMIT
   } state_type;

   localparam logic [5:0] SQ_LAST  = 6'(fpm_pkg::LOG_FRAC - 1);
   localparam logic [5:0] DIV_LAST = 6'(fpm_pkg::DIV_DIVIDEND_W - 1);

   state_type  state_ff, state_in;
   logic [5:0] cnt_ff, cnt_in;
   logic       second_ff, second_in;

   always_comb begin
      state_in    = state_ff;
      cnt_in      = cnt_ff;
      second_in   = second_ff;
      req_ready   = 1'b0;
      cmd.op      = fpm_pkg::OP_IDLE;
      cmd.pixel   = 1'b0;
      cmd.second  = second_ff;
      cmd.bit_idx = cnt_ff[4:0];
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            cmd.pixel = req_valid;
            if (req_valid && status.frame_last) begin
               state_in = S_WH;
            end
         end
         S_WH: begin
            cmd.op   = fpm_pkg::OP_WH;
            state_in = S_PEAK;
         end
         S_PEAK: begin
            cmd.op    = fpm_pkg::OP_PEAK;
            second_in = 1'b0;
            state_in  = status.sse_zero ? S_ROUND : S_NORM;
         end
         S_NORM: begin
            cmd.op = fpm_pkg::OP_NORM;
            if (status.msb_set) begin
               state_in = S_MANT;
            end
         end
         S_MANT: begin
            cmd.op   = fpm_pkg::OP_MANT;
            cnt_in   = SQ_LAST;
            state_in = S_SQ;
         end
         S_SQ: begin
            cmd.op   = fpm_pkg::OP_SQ;
            state_in = S_UPD;
         end
         S_UPD: begin
            cmd.op = fpm_pkg::OP_UPD;
            if (cnt_ff == 6'd0) begin
               state_in = S_SAVE;
            end else begin
               cnt_in   = cnt_ff - 6'd1;
               state_in = S_SQ;
            end
         end
         S_SAVE: begin
            cmd.op = fpm_pkg::OP_SAVE;
            if (!second_ff) begin
               second_in = 1'b1;
               state_in  = S_NORM;
            end else begin
               state_in = S_DIFF;
            end
         end
         S_DIFF: begin
            cmd.op   = fpm_pkg::OP_DIFF;
            state_in = S_ROUND;
         end
         S_ROUND: begin
            cmd.op   = fpm_pkg::OP_ROUND;
            state_in = S_ACC;
         end
         S_ACC: begin
            cmd.op   = fpm_pkg::OP_ACC;
            cnt_in   = DIV_LAST;
            state_in = S_DIV;
         end
         S_DIV: begin
            cmd.op = fpm_pkg::OP_DIV;
            if (cnt_ff == 6'd0) begin
               state_in = S_EMIT;
            end else begin
               cnt_in = cnt_ff - 6'd1;
            end
         end
         S_EMIT: begin
            if (status.out_free) begin
               cmd.op   = fpm_pkg::OP_EMIT;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         cnt_ff    <= 6'd0;
         second_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         cnt_ff    <= cnt_in;
         second_ff <= second_in;
      end
   end

endmodule

// File: rtl/core/fpm_dp.sv
// datapath: pixel sse accumulation, shared log2 unit, divider and result register
module fpm_dp #(
   parameter int unsigned MAX_WIDTH  = fpm_pkg::MAX_WIDTH_DEF,
   parameter int unsigned MAX_HEIGHT = fpm_pkg::MAX_HEIGHT_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  fpm_pkg::cfg_type               cfg,
   input  fpm_pkg::dp_cmd_type            cmd,
   output fpm_pkg::dp_status_type         status,
   input  logic [fpm_pkg::LUMA_W-1:0]     ref_luma,
   input  logic [fpm_pkg::LUMA_W-1:0]     test_luma,
   input  logic                           rsp_ready,
   output logic                           rsp_valid,
   output logic [fpm_pkg::INDEX_W-1:0]    frame_index,
   output logic [fpm_pkg::SSE_OUT_W-1:0]  frame_sse,
   output logic [fpm_pkg::PSNR_W-1:0]     frame_psnr_q8,
   output logic                           identical_frame,
   output logic [fpm_pkg::PSNR_W-1:0]     average_psnr_q8,
   output logic                           sequence_done
);

   localparam int unsigned DW_W  = $clog2(MAX_WIDTH + 1);
   localparam int unsigned DH_W  = $clog2(MAX_HEIGHT + 1);
   localparam int unsigned COL_W = $clog2(MAX_WIDTH);
   localparam int unsigned ROW_W = $clog2(MAX_HEIGHT);
   localparam int unsigned WH_W  = DW_W + DH_W;
   localparam int unsigned SSE_W = 16 + COL_W + ROW_W;
   localparam int unsigned X_W   = (SSE_W > 32) ? SSE_W : 32;
   localparam int unsigned LZ_W  = $clog2(X_W);
   localparam int unsigned LW    = fpm_pkg::LOG_W;
   localparam int unsigned PW    = fpm_pkg::PSNR_W;
   localparam int unsigned QW    = fpm_pkg::DIV_DIVIDEND_W;
   localparam int unsigned NW    = fpm_pkg::DIV_N_W;
   localparam int unsigned LOG_INT_WL = fpm_pkg::LOG_INT_W;

   // geometry clamp
   logic [DW_W-1:0] w_dim;
   logic [DH_W-1:0] h_dim;

   always_comb begin
      if (cfg.frame_width == '0) begin
         w_dim = DW_W'(1);
      end else if (32'(cfg.frame_width) > MAX_WIDTH) begin
         w_dim = DW_W'(MAX_WIDTH);
      end else begin
         w_dim = DW_W'(cfg.frame_width);
      end
      if (cfg.frame_height == '0) begin
         h_dim = DH_W'(1);
      end else if (32'(cfg.frame_height) > MAX_HEIGHT) begin
         h_dim = DH_W'(MAX_HEIGHT);
      end else begin
         h_dim = DH_W'(cfg.frame_height);
      end
   end

   logic [COL_W-1:0]  col_ff, col_in;
   logic [ROW_W-1:0]  row_ff, row_in;
   logic [SSE_W-1:0]  acc_ff, acc_in;
   logic [SSE_W-1:0]  sse_ff, sse_in;
   logic [WH_W-1:0]   wh_ff, wh_in;
   logic [X_W-1:0]    x_ff, x_in;
   logic [LZ_W-1:0]   lz_ff, lz_in;
   logic [31:0]       m_ff, m_in;
   logic [63:0]       prod_ff, prod_in;
   logic [LW-1:0]     r_ff, r_in;
   logic [LW-1:0]     ln_ff, ln_in;
   logic [LW-1:0]     ld_ff, ld_in;
   logic [PW-1:0]     psnr_ff, psnr_in;
   logic [31:0]       total_ff, total_in;
   logic [NW-1:0]     n_ff, n_in;
   logic [QW-1:0]     quo_ff, quo_in;
   logic [NW-1:0]     rem_ff, rem_in;
   logic [fpm_pkg::INDEX_W-1:0]   fc_ff, fc_in;
   logic                          vld_ff, vld_in;
   logic [fpm_pkg::INDEX_W-1:0]   idx_ff, idx_in;
   logic [fpm_pkg::SSE_OUT_W-1:0] osse_ff, osse_in;
   logic [PW-1:0]                 opsnr_ff, opsnr_in;
   logic                          oident_ff, oident_in;
   logic [PW-1:0]                 oavg_ff, oavg_in;
   logic                          odone_ff, odone_in;

   // pixel path
   logic [DW_W-1:0]             col_inc;
   logic [DH_W-1:0]             row_inc;
   logic                        last_col;
   logic                        last_row;
   logic [fpm_pkg::LUMA_W-1:0]  abs_diff;
   logic [15:0]                 diff_sq;
   logic [SSE_W-1:0]            acc_sum;

   assign col_inc  = DW_W'(col_ff) + DW_W'(1);
   assign row_inc  = DH_W'(row_ff) + DH_W'(1);
   assign last_col = (col_inc >= w_dim);
   assign last_row = (row_inc >= h_dim);
   assign abs_diff = (ref_luma >= test_luma) ? (ref_luma - test_luma) : (test_luma - ref_luma);
   assign diff_sq  = 16'(abs_diff) * 16'(abs_diff);
   assign acc_sum  = acc_ff + SSE_W'(diff_sq);

   // end-of-frame arithmetic
   logic [LOG_INT_WL-1:0] exp_int;
   logic [LW-1:0]         dlog;
   logic [63:0]           rounded;
   logic [63:0]           q_val;
   logic [31:0]           sum32;
   logic [NW-1:0]         n_next;
   logic [NW:0]           trial;
   logic                  qbit;
   logic [63:0]           sse_wide;
   logic                  seq_end;

   assign exp_int  = LOG_INT_WL'(X_W - 1) - LOG_INT_WL'(lz_ff);
   assign dlog     = ln_ff - ld_ff;
   assign rounded  = prod_ff + (64'd1 << (fpm_pkg::ROUND_SHIFT - 1));
   assign q_val    = rounded >> fpm_pkg::ROUND_SHIFT;
   assign sum32    = total_ff + 32'(psnr_ff);
   assign n_next   = NW'(fc_ff) + NW'(1);
   assign trial    = {rem_ff, quo_ff[QW-1]};
   assign qbit     = (trial >= (NW+1)'(n_ff));
   assign sse_wide = 64'(sse_ff);
   assign seq_end  = (n_ff >= NW'(cfg.sequence_frames));

   assign status.frame_last = last_col && last_row;
   assign status.sse_zero   = (sse_ff == '0);
   assign status.msb_set    = x_ff[X_W-1];
   assign status.out_free   = !vld_ff || rsp_ready;

   always_comb begin
      col_in    = col_ff;
      row_in    = row_ff;
      acc_in    = acc_ff;
      sse_in    = sse_ff;
      wh_in     = wh_ff;
      x_in      = x_ff;
      lz_in     = lz_ff;
      m_in      = m_ff;
      prod_in   = prod_ff;
      r_in      = r_ff;
      ln_in     = ln_ff;
      ld_in     = ld_ff;
      psnr_in   = psnr_ff;
      total_in  = total_ff;
      n_in      = n_ff;
      quo_in    = quo_ff;
      rem_in    = rem_ff;
      fc_in     = fc_ff;
      vld_in    = vld_ff && !rsp_ready;
      idx_in    = idx_ff;
      osse_in   = osse_ff;
      opsnr_in  = opsnr_ff;
      oident_in = oident_ff;
      oavg_in   = oavg_ff;
      odone_in  = odone_ff;

      if (cmd.pixel) begin
         if (last_col) begin
            col_in = '0;
            if (last_row) begin
               row_in = '0;
               sse_in = acc_sum;
               acc_in = '0;
            end else begin
               row_in = ROW_W'(row_inc);
               acc_in = acc_sum;
            end
         end else begin
            col_in = COL_W'(col_inc);
            acc_in = acc_sum;
         end
      end

      case (cmd.op)
         fpm_pkg::OP_IDLE: begin
         end
         fpm_pkg::OP_WH: begin
            wh_in = WH_W'(w_dim) * WH_W'(h_dim);
         end
         fpm_pkg::OP_PEAK: begin
            x_in  = X_W'(wh_ff) * X_W'(fpm_pkg::PEAK_SQ);
            lz_in = '0;
         end
         fpm_pkg::OP_NORM: begin
            if (!x_ff[X_W-1]) begin
               x_in  = x_ff << 1;
               lz_in = lz_ff + LZ_W'(1);
            end
         end
         fpm_pkg::OP_MANT: begin
            m_in = x_ff[X_W-1 -: 32];
            r_in = {exp_int, {fpm_pkg::LOG_FRAC{1'b0}}};
         end
         fpm_pkg::OP_SQ: begin
            prod_in = 64'(m_ff) * 64'(m_ff);
         end
         fpm_pkg::OP_UPD: begin
            // square lands in [1,4): renormalize and emit one log bit
            if (prod_ff[63]) begin
               m_in             = prod_ff[63:32];
               r_in[cmd.bit_idx] = 1'b1;
            end else begin
               m_in = prod_ff[62:31];
            end
         end
         fpm_pkg::OP_SAVE: begin
            if (!cmd.second) begin
               ln_in = r_ff;
               x_in  = X_W'(sse_ff);
               lz_in = '0;
            end else begin
               ld_in = r_ff;
            end
         end
         fpm_pkg::OP_DIFF: begin
            prod_in = 64'((LW + 32)'(dlog) * (LW + 32)'(fpm_pkg::TEN_LOG10_2_Q30));
         end
         fpm_pkg::OP_ROUND: begin
            if (sse_ff == '0) begin
               psnr_in = fpm_pkg::PSNR_SAT;
            end else if (ld_ff >= ln_ff) begin
               psnr_in = '0;
            end else if (q_val > 64'(fpm_pkg::PSNR_SAT)) begin
               psnr_in = fpm_pkg::PSNR_SAT;
            end else begin
               psnr_in = q_val[PW-1:0];
            end
         end
         fpm_pkg::OP_ACC: begin
            total_in = sum32;
            n_in     = n_next;
            quo_in   = QW'(sum32) + QW'(n_next >> 1);
            rem_in   = '0;
         end
         fpm_pkg::OP_DIV: begin
            if (qbit) begin
               rem_in = NW'(trial - (NW+1)'(n_ff));
            end else begin
               rem_in = NW'(trial);
            end
            quo_in = {quo_ff[QW-2:0], qbit};
         end
         fpm_pkg::OP_EMIT: begin
            vld_in    = 1'b1;
            idx_in    = fc_ff;
            osse_in   = sse_wide[fpm_pkg::SSE_OUT_W-1:0];
            opsnr_in  = psnr_ff;
            oident_in = (sse_ff == '0);
            oavg_in   = (quo_ff > QW'(fpm_pkg::PSNR_SAT)) ? fpm_pkg::PSNR_SAT : quo_ff[PW-1:0];
            odone_in  = seq_end;
            if (seq_end) begin
               fc_in    = '0;
               total_in = '0;
            end else begin
               fc_in = n_ff[fpm_pkg::INDEX_W-1:0];
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff   <= '0;
         row_ff   <= '0;
         acc_ff   <= '0;
         fc_ff    <= '0;
         total_ff <= '0;
         vld_ff   <= 1'b0;
      end else begin
         col_ff   <= col_in;
         row_ff   <= row_in;
         acc_ff   <= acc_in;
         fc_ff    <= fc_in;
         total_ff <= total_in;
         vld_ff   <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      sse_ff    <= sse_in;
      wh_ff     <= wh_in;
      x_ff      <= x_in;
      lz_ff     <= lz_in;
      m_ff      <= m_in;
      prod_ff   <= prod_in;
      r_ff      <= r_in;
      ln_ff     <= ln_in;
      ld_ff     <= ld_in;
      psnr_ff   <= psnr_in;
      n_ff      <= n_in;
      quo_ff    <= quo_in;
      rem_ff    <= rem_in;
      idx_ff    <= idx_in;
      osse_ff   <= osse_in;
      opsnr_ff  <= opsnr_in;
      oident_ff <= oident_in;
      oavg_ff   <= oavg_in;
      odone_ff  <= odone_in;
   end

   assign rsp_valid       = vld_ff;
   assign frame_index     = idx_ff;
   assign frame_sse       = osse_ff;
   assign frame_psnr_q8   = opsnr_ff;
   assign identical_frame = oident_ff;
   assign average_psnr_q8 = oavg_ff;
   assign sequence_done   = odone_ff;

endmodule

// File: rtl/core/frame_psnr_meter.sv
// top level of the luma psnr meter: csr block, controller and datapath
// pixel pairs: one beat per cycle; input held off from a frame's last beat until its result is out
// frame close: log2 of the peak sum and of the sse (skipped for a zero sse), psnr and average,
//   plus any wait for the output register
// shared log2 unit takes 24 squaring steps per operand (a square state, then an update state), the divider 33 steps
// synchronous active-high reset clears counters, sse and psnr totals, registers to 176/144/300
module frame_psnr_meter #(
   parameter int unsigned MAX_WIDTH  = fpm_pkg::MAX_WIDTH_DEF,
   parameter int unsigned MAX_HEIGHT = fpm_pkg::MAX_HEIGHT_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   fpm_req_if.sink                           req_if,
   fpm_rsp_if.source                         rsp_if,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [fpm_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [fpm_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [fpm_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                              csr_pready
);

   // config registers
   fpm_pkg::cfg_type       cfg_ff, cfg_in;
   fpm_pkg::csr_index_type csr_idx;
   logic                   csr_write;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign csr_idx    = fpm_pkg::csr_index_type'(csr_paddr[3:2]);

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         case (csr_idx)
            fpm_pkg::CSR_FRAME_WIDTH: begin
               cfg_in.frame_width = csr_pwdata[fpm_pkg::DIM_CFG_W-1:0];
            end
            fpm_pkg::CSR_FRAME_HEIGHT: begin
               cfg_in.frame_height = csr_pwdata[fpm_pkg::DIM_CFG_W-1:0];
            end
            fpm_pkg::CSR_SEQUENCE_FRAMES: begin
               cfg_in.sequence_frames = csr_pwdata[fpm_pkg::SEQ_CFG_W-1:0];
            end
            default: begin
               // addresses past the register list are ignored
            end
         endcase
      end
   end

   always_comb begin
      case (csr_idx)
         fpm_pkg::CSR_FRAME_WIDTH:     csr_prdata = 32'(cfg_ff.frame_width);
         fpm_pkg::CSR_FRAME_HEIGHT:    csr_prdata = 32'(cfg_ff.frame_height);
         fpm_pkg::CSR_SEQUENCE_FRAMES: csr_prdata = 32'(cfg_ff.sequence_frames);
         default:                      csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.frame_width     <= 12'd176;
         cfg_ff.frame_height    <= 12'd144;
         cfg_ff.sequence_frames <= 16'd300;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // controller and datapath
   fpm_pkg::dp_cmd_type    cmd;
   fpm_pkg::dp_status_type status;

   fpm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_if.ready),
      .status    (status),
      .cmd       (cmd)
   );

   fpm_dp #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg_ff),
      .cmd             (cmd),
      .status          (status),
      .ref_luma        (req_if.ref_luma),
      .test_luma       (req_if.test_luma),
      .rsp_ready       (rsp_if.ready),
      .rsp_valid       (rsp_if.valid),
      .frame_index     (rsp_if.frame_index),
      .frame_sse       (rsp_if.frame_sse),
      .frame_psnr_q8   (rsp_if.frame_psnr_q8),
      .identical_frame (rsp_if.identical_frame),
      .average_psnr_q8 (rsp_if.average_psnr_q8),
      .sequence_done   (rsp_if.sequence_done)
   );

   // the last beat of a frame stops the pixel stream for the close-out
   a_stall_after_frame: assert property (@(posedge clock) disable iff (reset)
      (req_if.valid && req_if.ready && status.frame_last) |=> !req_if.ready)
      else $error("pixel beat accepted right after frame end");

   // zero sse always reports the saturated psnr
   a_ident_sat: assert property (@(posedge clock) disable iff (reset)
      (rsp_if.valid && rsp_if.identical_frame) |-> (rsp_if.frame_psnr_q8 == fpm_pkg::PSNR_SAT))
      else $error("identical frame without saturated psnr");

   // the frame counter wraps through sequence end before reaching all ones
   a_index_range: assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid |-> (rsp_if.frame_index != 16'hffff))
      else $error("frame index out of range");

endmodule
